/* sv/gtb_pkg.sv */
// gtb_pkg: shared types and codes for the glyph text blitter
// used by gtb_pixel_unit, gtb_glyph_store and glyph_text_blitter
package gtb_pkg;

    typedef enum logic [2:0] {
        CMD_SET_CURSOR = 3'd0,
        CMD_LOAD_ROW   = 3'd1,
        CMD_DRAW_CHAR  = 3'd2,
        CMD_HLINE      = 3'd3,
        CMD_READ_BYTE  = 3'd4,
        CMD_NOP        = 3'd5
    } gtb_cmd_t;

    typedef enum logic [2:0] {
        CFG_GLYPH_WIDTH   = 3'd0,
        CFG_GLYPH_HEIGHT  = 3'd1,
        CFG_VERTICAL_MODE = 3'd2,
        CFG_IMAGE_WIDTH   = 3'd3,
        CFG_IMAGE_HEIGHT  = 3'd4
    } gtb_cfg_idx_t;

    localparam logic [20:0] CODE_NEWLINE = 21'd10;

    // one pixel write or one byte read for the pixel unit
    typedef struct packed {
        logic        go;
        logic        rd;
        logic [16:0] x;
        logic [16:0] y;
        logic        val;
        logic [12:0] addr;
    } gtb_pix_req_t;

    typedef struct packed {
        logic       idle;
        logic       done;
        logic [7:0] rdata;
    } gtb_pix_rsp_t;

    typedef struct packed {
        logic        en;
        logic [4:0]  row;
        logic [15:0] bits;
    } gtb_glyph_wr_t;

endpackage

/* sv/gtb_pixel_unit.sv */
// gtb_pixel_unit: framebuffer memory with the pixel address multiplier
// and byte read-modify-write; depends on gtb_pkg
module gtb_pixel_unit import gtb_pkg::*; #(
    parameter int FB_BYTES = 8192
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [12:0]  image_width,
    input  logic [13:0]  image_height,
    input  gtb_pix_req_t req,
    output gtb_pix_rsp_t rsp
);
    localparam int AW = $clog2(FB_BYTES);

    typedef enum logic [2:0] {
        PU_CLEAR, PU_IDLE, PU_ADDR, PU_RD, PU_WR, PU_RDB, PU_RDB2
    } pu_state_t;

    pu_state_t       state_reg;
    logic [AW-1:0]   clr_reg;
    logic [AW-1:0]   b_reg;
    logic            ok_reg;
    logic [16:0]     x_reg;
    logic [16:0]     y_reg;
    logic            val_reg;
    logic [24:0]     limit_reg;
    logic [10:0]     row_bytes;
    logic [28:0]     b_full;
    logic [7:0]      mem [FB_BYTES];
    logic [7:0]      rdata_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [7:0]      wdata;
    logic [7:0]      mask;

    assign row_bytes = 11'((14'(image_width) + 14'd7) >> 3);
    assign b_full    = 29'(y_reg) * 29'(row_bytes) + 29'(x_reg >> 3);
    assign mask      = 8'h80 >> x_reg[2:0];

    always_comb begin
        we    = 1'b0;
        waddr = b_reg;
        wdata = val_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);
        if (state_reg == PU_CLEAR) begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = 8'd0;
        end else if (state_reg == PU_WR) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[b_reg];
    end

    always_ff @(posedge aclk) begin
        limit_reg <= 25'(image_height) * 25'(row_bytes);
        if (!aresetn) begin
            state_reg <= PU_CLEAR;
            clr_reg   <= '0;
        end else begin
            case (state_reg)
                PU_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(FB_BYTES - 1)) begin
                        state_reg <= PU_IDLE;
                    end
                end
                PU_IDLE: begin
                    if (req.go) begin
                        x_reg   <= req.x;
                        y_reg   <= req.y;
                        val_reg <= req.val;
                        if (req.rd) begin
                            b_reg     <= AW'(req.addr);
                            state_reg <= PU_RDB;
                        end else begin
                            state_reg <= PU_ADDR;
                        end
                    end
                end
                PU_ADDR: begin
                    b_reg     <= b_full[AW-1:0];
                    ok_reg    <= (b_full < 29'(limit_reg)) && (32'(b_full) < 32'(FB_BYTES));
                    state_reg <= PU_RD;
                end
                PU_RD:   state_reg <= ok_reg ? PU_WR : PU_IDLE;
                PU_WR:   state_reg <= PU_IDLE;
                PU_RDB:  state_reg <= PU_RDB2;
                PU_RDB2: state_reg <= PU_IDLE;
                default: state_reg <= PU_IDLE;
            endcase
        end
    end

    assign rsp.idle  = (state_reg == PU_IDLE);
    assign rsp.done  = (state_reg == PU_WR) || (state_reg == PU_RDB2)
                    || (state_reg == PU_RD && !ok_reg);
    assign rsp.rdata = rdata_reg;

endmodule

/* sv/gtb_glyph_store.sv */
// gtb_glyph_store: glyph row memory and glyph present bits
// present bits are swept clear after reset; depends on gtb_pkg
module gtb_glyph_store import gtb_pkg::*; #(
    parameter int GLYPH_COUNT    = 1024,
    parameter int MAX_GLYPH_ROWS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [$clog2(GLYPH_COUNT)-1:0] code_idx,
    input  gtb_glyph_wr_t                  wr,
    input  logic [6:0]                     row_j,
    output logic                           pres_q,
    output logic [15:0]                    row_q,
    output logic                           clear_done
);
    localparam int CW = $clog2(GLYPH_COUNT);
    localparam int RA = $clog2(GLYPH_COUNT * MAX_GLYPH_ROWS);

    logic [15:0]   rows [GLYPH_COUNT * MAX_GLYPH_ROWS];
    logic          pres [GLYPH_COUNT];
    logic [CW-1:0] clr_reg;
    logic          clearing_reg;
    logic [RA-1:0] raddr;
    logic [6:0]    rsel;

    assign rsel  = wr.en ? 7'(wr.row) : row_j;
    assign raddr = RA'(code_idx) * RA'(MAX_GLYPH_ROWS) + RA'(rsel);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            rows[raddr] <= wr.bits;
        end
        row_q <= rows[raddr];
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            pres[clr_reg] <= 1'b0;
        end else if (wr.en) begin
            pres[code_idx] <= 1'b1;
        end
        pres_q <= pres[code_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end else if (clearing_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == CW'(GLYPH_COUNT - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign clear_done = !clearing_reg;

endmodule

/* sv/glyph_text_blitter.sv */
// glyph_text_blitter: 1bpp bitmap text renderer, top level and command sequencer
// depends on gtb_pkg, gtb_pixel_unit, gtb_glyph_store
//
// channel   direction  payload
// s_        in         tuser: cmd; tdata: code, row, bits, x, y, end x, byte addr
// m_        out        tdata: read_data, cursor_x_out, cursor_y_out
// cfg_      in         cfg_index, cfg_data register write, always ready
//
// after reset the clearing passes of the pixel unit and the glyph store run before s_tready
// draw char: each pixel a read-modify-write in the pixel unit
// hline: sets each pixel from x to end x the same way; read byte reads one framebuffer byte
// one item at a time; the result register frees the input side while m_ is stalled
module glyph_text_blitter import gtb_pkg::*; #(
    parameter int FB_BYTES       = 8192,
    parameter int GLYPH_COUNT    = 1024,
    parameter int MAX_GLYPH_ROWS = 32,
    parameter int MAX_GLYPH_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,   // cmd
    // char_code, row_index, row_bits, pos_x, pos_y, end_x, byte_addr, pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data, cursor_x_out, cursor_y_out
    output logic [39:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [13:0]  cfg_data
);
    localparam int CW = $clog2(GLYPH_COUNT);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_PRES, S_ROW, S_ROWL, S_PIX, S_PWAIT,
        S_ADV, S_HPIX, S_HWAIT, S_RDW, S_OUT
    } state_t;

    state_t       state_reg;
    logic [4:0]   gw_reg;
    logic [5:0]   gh_reg;
    logic         vert_reg;
    logic [12:0]  iw_reg;
    logic [13:0]  ih_reg;
    logic [2:0]   cmd_reg;
    logic [20:0]  code_reg;
    logic [4:0]   ridx_reg;
    logic [15:0]  bits_reg;
    logic [15:0]  px_reg;
    logic [15:0]  py_reg;
    logic [15:0]  ex_reg;
    logic [12:0]  addr_reg;
    logic [15:0]  cx_reg, cy_reg, ox_reg, oy_reg;
    logic [16:0]  hx_reg;
    logic [5:0]   i_reg;
    logic [6:0]   j_reg;
    logic         have_reg;
    logic [15:0]  row_reg;
    logic [7:0]   data_reg;
    logic         m_valid_reg;
    logic [39:0]  m_data_reg;

    logic [5:0]   w_eff, wd, p;
    logic [6:0]   h_eff;
    logic         code_ok, pix_val, pres_q, store_ready;
    logic [15:0]  row_q;
    gtb_pix_req_t pix_req;
    gtb_pix_rsp_t pix_rsp;
    gtb_glyph_wr_t gwr;

    assign w_eff = (6'(gw_reg) < 6'(MAX_GLYPH_BITS)) ? 6'(gw_reg) : 6'(MAX_GLYPH_BITS);
    assign h_eff = (7'(gh_reg) < 7'(MAX_GLYPH_ROWS)) ? 7'(gh_reg) : 7'(MAX_GLYPH_ROWS);
    assign wd    = 6'(((w_eff + 6'd7) >> 3) << 3);
    assign p     = wd - 6'd1 - i_reg;
    assign code_ok = code_reg < 21'(GLYPH_COUNT);

    always_comb begin
        if (have_reg) begin
            pix_val = (p < 6'd16) && row_reg[p[3:0]];
        end else begin
            pix_val = vert_reg ? 1'b1 : (i_reg[0] ^ j_reg[0]);
        end
    end

    always_comb begin
        pix_req.go   = (state_reg == S_PIX) || (state_reg == S_HPIX)
                    || (state_reg == S_DISPATCH && cmd_reg == CMD_READ_BYTE
                        && 21'(addr_reg) < 21'(FB_BYTES));
        pix_req.rd   = (state_reg == S_DISPATCH);
        pix_req.addr = addr_reg;
        pix_req.val  = (state_reg == S_HPIX) ? 1'b1 : pix_val;
        if (state_reg == S_HPIX) begin
            pix_req.x = hx_reg;
            pix_req.y = 17'(py_reg);
        end else if (vert_reg) begin
            pix_req.x = 17'(cx_reg) + 17'(j_reg);
            pix_req.y = 17'(cy_reg) + 17'(i_reg);
        end else begin
            pix_req.x = 17'(cx_reg) + 17'(i_reg);
            pix_req.y = 17'(cy_reg) + 17'(j_reg);
        end
    end

    assign gwr.en   = (state_reg == S_DISPATCH) && (cmd_reg == CMD_LOAD_ROW) && code_ok
                   && (7'(ridx_reg) < 7'(MAX_GLYPH_ROWS));
    assign gwr.row  = ridx_reg;
    assign gwr.bits = bits_reg;

    gtb_pixel_unit #(.FB_BYTES(FB_BYTES)) u_pix (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (iw_reg),
        .image_height (ih_reg),
        .req          (pix_req),
        .rsp          (pix_rsp)
    );

    gtb_glyph_store #(.GLYPH_COUNT(GLYPH_COUNT), .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS)) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .code_idx   (code_reg[CW-1:0]),
        .wr         (gwr),
        .row_j      (j_reg),
        .pres_q     (pres_q),
        .row_q      (row_q),
        .clear_done (store_ready)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            gw_reg      <= 5'd8;
            gh_reg      <= 6'd16;
            vert_reg    <= 1'b0;
            iw_reg      <= 13'd512;
            ih_reg      <= 14'd128;
            cx_reg      <= '0;
            cy_reg      <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_GLYPH_WIDTH:   gw_reg   <= cfg_data[4:0];
                    CFG_GLYPH_HEIGHT:  gh_reg   <= cfg_data[5:0];
                    CFG_VERTICAL_MODE: vert_reg <= cfg_data[0];
                    CFG_IMAGE_WIDTH:   iw_reg   <= cfg_data[12:0];
                    CFG_IMAGE_HEIGHT:  ih_reg   <= cfg_data[13:0];
                    default: ;
                endcase
            end
            // S_OUT sets the valid itself
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    if (pix_rsp.idle && store_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= s_tuser;
                        code_reg  <= s_tdata[20:0];
                        ridx_reg  <= s_tdata[25:21];
                        bits_reg  <= s_tdata[41:26];
                        px_reg    <= s_tdata[57:42];
                        py_reg    <= s_tdata[73:58];
                        ex_reg    <= s_tdata[89:74];
                        addr_reg  <= s_tdata[102:90];
                        data_reg  <= '0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    state_reg <= S_OUT;
                    case (cmd_reg)
                        CMD_SET_CURSOR: begin
                            cx_reg <= px_reg;
                            ox_reg <= px_reg;
                            cy_reg <= py_reg;
                            oy_reg <= py_reg;
                        end
                        CMD_DRAW_CHAR: begin
                            if (code_reg == CODE_NEWLINE) begin
                                if (vert_reg) begin
                                    cy_reg <= oy_reg;
                                    cx_reg <= cx_reg + 16'(h_eff);
                                end else begin
                                    cx_reg <= ox_reg;
                                    cy_reg <= cy_reg + 16'(h_eff);
                                end
                            end else begin
                                state_reg <= S_PRES;
                            end
                        end
                        CMD_HLINE: begin
                            hx_reg <= 17'(px_reg);
                            if (ex_reg >= px_reg) begin
                                state_reg <= S_HPIX;
                            end
                        end
                        CMD_READ_BYTE: begin
                            if (21'(addr_reg) < 21'(FB_BYTES)) begin
                                state_reg <= S_RDW;
                            end
                        end
                        default: ;
                    endcase
                end
                S_PRES: begin
                    have_reg  <= code_ok && pres_q;
                    j_reg     <= '0;
                    state_reg <= (h_eff == 7'd0) ? S_ADV : S_ROW;
                end
                S_ROW: state_reg <= S_ROWL;
                S_ROWL: begin
                    row_reg <= row_q;
                    i_reg   <= '0;
                    if (w_eff == 6'd0) begin
                        j_reg     <= j_reg + 7'd1;
                        state_reg <= (j_reg + 7'd1 == h_eff) ? S_ADV : S_ROW;
                    end else begin
                        state_reg <= S_PIX;
                    end
                end
                S_PIX: state_reg <= S_PWAIT;
                S_PWAIT: begin
                    if (pix_rsp.done) begin
                        if (i_reg + 6'd1 == w_eff) begin
                            j_reg     <= j_reg + 7'd1;
                            state_reg <= (j_reg + 7'd1 == h_eff) ? S_ADV : S_ROW;
                        end else begin
                            i_reg     <= i_reg + 6'd1;
                            state_reg <= S_PIX;
                        end
                    end
                end
                S_ADV: begin
                    if (vert_reg) begin
                        cy_reg <= cy_reg + 16'(w_eff);
                    end else begin
                        cx_reg <= cx_reg + 16'(w_eff);
                    end
                    state_reg <= S_OUT;
                end
                S_HPIX: state_reg <= S_HWAIT;
                S_HWAIT: begin
                    if (pix_rsp.done) begin
                        if (hx_reg == 17'(ex_reg)) begin
                            state_reg <= S_OUT;
                        end else begin
                            hx_reg    <= hx_reg + 17'd1;
                            state_reg <= S_HPIX;
                        end
                    end
                end
                S_RDW: begin
                    if (pix_rsp.done) begin
                        data_reg  <= pix_rsp.rdata;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {cy_reg, cx_reg, data_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the pixel unit only gets a request when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        pix_req.go |-> pix_rsp.idle)
        else $error("pixel request while pixel unit busy");

    // a response only comes while the sequencer waits for one
    assert property (@(posedge aclk) disable iff (!aresetn)
        pix_rsp.done |-> (state_reg == S_PWAIT || state_reg == S_HWAIT || state_reg == S_RDW))
        else $error("unexpected pixel unit response");

    // an accepted item leaves the idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DISPATCH && !s_tready))
        else $error("item accepted without dispatch");

    // no item is taken before both clearing passes are over
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (store_ready && state_reg != S_INIT))
        else $error("ready during clearing pass");

endmodule
